>>> sv/mqtt_receive_packet_parser_macros.svh
// ----------------------------------------------------------------------------
// MQTT receive packet parser: assertion macros
// Shorthand for the concurrent checks at the end of the top level. The
// macros expect signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef MQTT_RECEIVE_PACKET_PARSER_MACROS_SVH
`define MQTT_RECEIVE_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MRP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mrp_pkg.sv
// ----------------------------------------------------------------------------
// MQTT receive packet parser package
// Shared types and constants: parser phase, summary status codes, packet
// type codes and the summary record carried to the output stage.
// ----------------------------------------------------------------------------
package mrp_pkg;

  // Longest remaining-length field, in bytes (1..4)
  localparam int unsigned MAX_LEN_BYTES = 4;

  // Protocol level at which DISCONNECT and AUTH become legal
  localparam logic [2:0] PROTO_V5      = 3'd5;
  localparam logic [2:0] PROTO_DEFAULT = 3'd4;

  // Control packet types
  localparam logic [3:0] PT_CONNACK    = 4'd2;
  localparam logic [3:0] PT_PUBLISH    = 4'd3;
  localparam logic [3:0] PT_PUBACK     = 4'd4;
  localparam logic [3:0] PT_PUBREC     = 4'd5;
  localparam logic [3:0] PT_PUBREL     = 4'd6;
  localparam logic [3:0] PT_PUBCOMP    = 4'd7;
  localparam logic [3:0] PT_SUBACK     = 4'd9;
  localparam logic [3:0] PT_DISCONNECT = 4'd14;
  localparam logic [3:0] PT_AUTH       = 4'd15;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_BODY
  } mrp_phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_SHORT    = 2'd3
  } mrp_status_t;

  // One packet summary
  typedef struct packed {
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [27:0] pkt_len;
    logic [15:0] message_id;
    logic [15:0] topic_length;
    logic [27:0] payload_length;
    logic [7:0]  ack_flags;
    logic [7:0]  reason_code;
    logic [15:0] code_count;
    logic [7:0]  first_code;
    mrp_status_t status;
  } mrp_result_t;

endpackage

>>> sv/mqtt_receive_packet_parser.sv
// ----------------------------------------------------------------------------
// MQTT receive packet parser
// Parses a received MQTT byte stream and reports one summary per packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) carries one stream byte
//   per transfer. Output channel (out_valid / out_stall / out_*) carries one
//   packet summary per transfer, produced on the last byte of each packet, or
//   early when the length field runs past four bytes.
//   Config channel (cfg_valid / cfg_ready / cfg_protocol_version) sets the
//   protocol level; cfg_ready is always high. Write it only while idle.
// Timing:
//   Every byte is consumed in the cycle it is taken, so the block sustains
//   one byte per clock while in_stall is low. Each summary is registered
//   into the output register, or into its one skid entry while the output
//   stalls; in_stall rises only while both hold summaries not yet taken.
// Reset (rst_n low, synchronous): parser waits for a fixed header byte, both
//   output entries are empty and the protocol level returns to 4.
// ----------------------------------------------------------------------------
`include "mqtt_receive_packet_parser_macros.svh"

module mqtt_receive_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // Summary output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_packet_type,
  output logic [3:0]  out_header_flags,
  output logic [27:0] out_pkt_len,
  output logic [15:0] out_message_id,
  output logic [15:0] out_topic_length,
  output logic [27:0] out_payload_length,
  output logic [7:0]  out_ack_flags,
  output logic [7:0]  out_reason_code,
  output logic [15:0] out_code_count,
  output logic [7:0]  out_first_code,
  output logic [1:0]  out_status,
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_protocol_version
);

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 res_vld;
  mrp_pkg::mrp_result_t res;

  logic [2:0]           proto_r;
  logic                 out_valid_r, out_valid_nxt;
  mrp_pkg::mrp_result_t out_data_r, out_data_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  mrp_pkg::mrp_result_t skid_data_r, skid_data_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !skid_valid_r;
  assign out_xfer  = out_valid_r && !out_stall;

  // Protocol level register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r <= mrp_pkg::PROTO_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      proto_r <= cfg_protocol_version;
    end
  end

  mrp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_xfer),
    .rx_byte  (in_rx_byte),
    .proto_v5 (proto_r >= mrp_pkg::PROTO_V5),
    .res_vld  (res_vld),
    .res      (res)
  );

  // Output register plus skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_xfer) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    // A new summary only arrives while the skid entry is empty
    if (res_vld) begin
      if (!out_valid_r || out_xfer) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_packet_type      = out_data_r.packet_type;
  assign out_header_flags     = out_data_r.header_flags;
  assign out_pkt_len          = out_data_r.pkt_len;
  assign out_message_id       = out_data_r.message_id;
  assign out_topic_length     = out_data_r.topic_length;
  assign out_payload_length   = out_data_r.payload_length;
  assign out_ack_flags        = out_data_r.ack_flags;
  assign out_reason_code      = out_data_r.reason_code;
  assign out_code_count       = out_data_r.code_count;
  assign out_first_code       = out_data_r.first_code;
  assign out_status           = out_data_r.status;

  // Checks
  `MRP_ASSERT_SAME(a_skid_behind_head, skid_valid_r, out_valid_r, "skid entry without head entry")
  `MRP_ASSERT_SAME(a_res_needs_byte, res_vld, in_xfer, "summary without a byte transfer")
  `MRP_ASSERT_NEXT(a_stall_holds_two, out_valid_r && out_stall && res_vld, skid_valid_r && out_valid_r, "summary lost behind stalled output")
  `MRP_ASSERT_SAME(a_reject_zero, out_valid_r && out_status != mrp_pkg::ST_ACCEPTED, out_message_id == 16'd0 && out_payload_length == 28'd0 && out_code_count == 16'd0, "rejected summary carries fields")
  `MRP_ASSERT_SAME(a_too_long_len, out_valid_r && out_status == mrp_pkg::ST_TOO_LONG, out_pkt_len == 28'd0, "over-long length reports nonzero length")

endmodule

>>> sv/mrp_core.sv
// ----------------------------------------------------------------------------
// MQTT receive parser core
// Byte-wide state machine: fixed header, variable length field, body field
// capture and the end-of-packet summary, all settled in the cycle a byte is
// taken. The summary is combinational; the caller registers it.
// ----------------------------------------------------------------------------
module mrp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  logic [7:0]          rx_byte,
  input  logic                proto_v5,
  output logic                res_vld,
  output mrp_pkg::mrp_result_t res
);

  mrp_pkg::mrp_phase_t phase_r, phase_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [27:0] len_acc_r, len_acc_nxt;
  logic [2:0]  len_cnt_r, len_cnt_nxt;
  logic [27:0] left_r, left_nxt;
  logic [27:0] pos_r, pos_nxt;
  logic [15:0] topic_r, topic_nxt;
  logic [15:0] msg_r, msg_nxt;
  logic [15:0] connack_r, connack_nxt;
  logic [23:0] suback_r, suback_nxt;

  logic [27:0] len_term;
  logic [3:0]  cur_type;
  logic        qos_nz;
  logic [15:0] sub_cnt;
  logic [7:0]  sub_fc;

  // Build the summary record for the packet that just ended
  function automatic mrp_pkg::mrp_result_t summarize(
    input logic [7:0]  hdr,
    input logic        too_long,
    input logic [27:0] rl,
    input logic [15:0] topic,
    input logic [15:0] msg,
    input logic [15:0] connack,
    input logic [23:0] suback,
    input logic        v5
  );
    mrp_pkg::mrp_result_t r;
    logic [3:0]  t;
    logic        handled;
    logic [28:0] need;
    logic [27:0] rest;
    r                  = '0;
    t                  = hdr[7:4];
    r.packet_type      = t;
    r.header_flags     = hdr[3:0];
    r.pkt_len          = rl;
    r.status           = mrp_pkg::ST_ACCEPTED;
    need               = {13'd0, topic} + 29'd2;
    rest               = rl - need[27:0];
    unique case (t)
      mrp_pkg::PT_CONNACK, mrp_pkg::PT_PUBLISH, mrp_pkg::PT_PUBACK,
      mrp_pkg::PT_PUBREC, mrp_pkg::PT_PUBREL, mrp_pkg::PT_PUBCOMP,
      mrp_pkg::PT_SUBACK:                         handled = 1'b1;
      mrp_pkg::PT_DISCONNECT, mrp_pkg::PT_AUTH:   handled = v5;
      default:                                    handled = 1'b0;
    endcase
    if (too_long) begin
      r.status = mrp_pkg::ST_TOO_LONG;
    end else if (!handled) begin
      r.status = mrp_pkg::ST_IGNORED;
    end else begin
      unique case (t)
        mrp_pkg::PT_PUBLISH: begin
          if (rl < 28'd2 || need > {1'b0, rl}) begin
            r.status = mrp_pkg::ST_SHORT;
          end else if (hdr[2:1] != 2'd0) begin
            if (rest < 28'd2) begin
              r.status = mrp_pkg::ST_SHORT;
            end else begin
              r.message_id     = msg;
              r.topic_length   = topic;
              r.payload_length = rest - 28'd2;
            end
          end else begin
            r.topic_length   = topic;
            r.payload_length = rest;
          end
        end
        mrp_pkg::PT_CONNACK: begin
          if (rl < 28'd2) begin
            r.status = mrp_pkg::ST_SHORT;
          end else begin
            r.ack_flags   = connack[15:8];
            r.reason_code = connack[7:0];
          end
        end
        mrp_pkg::PT_SUBACK: begin
          if (rl < 28'd3) begin
            r.status = mrp_pkg::ST_SHORT;
          end else begin
            r.message_id = msg;
            r.code_count = suback[23:8];
            r.first_code = suback[7:0];
          end
        end
        mrp_pkg::PT_DISCONNECT: begin
          r.status = mrp_pkg::ST_ACCEPTED;
        end
        default: begin
          if (rl < 28'd2) begin
            r.status = mrp_pkg::ST_SHORT;
          end else begin
            r.message_id = msg;
          end
        end
      endcase
    end
    return r;
  endfunction

  assign cur_type = hdr_r[7:4];
  assign qos_nz   = (hdr_r[2:1] != 2'd0);
  assign sub_cnt  = suback_r[23:8];
  assign sub_fc   = suback_r[7:0];

  // Seven payload bits of a length byte at their place
  always_comb begin
    unique case (len_cnt_r[1:0])
      2'd0:    len_term = {21'd0, rx_byte[6:0]};
      2'd1:    len_term = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_term = {7'd0, rx_byte[6:0], 14'd0};
      default: len_term = {rx_byte[6:0], 21'd0};
    endcase
  end

  // Next state and summary
  always_comb begin
    phase_nxt   = phase_r;
    hdr_nxt     = hdr_r;
    len_acc_nxt = len_acc_r;
    len_cnt_nxt = len_cnt_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    topic_nxt   = topic_r;
    msg_nxt     = msg_r;
    connack_nxt = connack_r;
    suback_nxt  = suback_r;
    res_vld     = 1'b0;
    res         = summarize(hdr_r, 1'b0, 28'd0, topic_r, msg_r, connack_r, suback_r,
                            proto_v5);
    if (byte_vld) begin
      unique case (phase_r)
        mrp_pkg::PH_IDLE: begin
          hdr_nxt     = rx_byte;
          len_acc_nxt = '0;
          len_cnt_nxt = '0;
          left_nxt    = '0;
          pos_nxt     = '0;
          topic_nxt   = '0;
          msg_nxt     = '0;
          connack_nxt = '0;
          suback_nxt  = '0;
          phase_nxt   = mrp_pkg::PH_LEN;
        end
        mrp_pkg::PH_LEN: begin
          len_acc_nxt = len_acc_r + len_term;
          len_cnt_nxt = len_cnt_r + 3'd1;
          if (rx_byte[7]) begin
            if (len_cnt_nxt >= 3'(mrp_pkg::MAX_LEN_BYTES)) begin
              // Continuation on the last allowed length byte
              len_cnt_nxt = '0;
              phase_nxt   = mrp_pkg::PH_IDLE;
              res_vld     = 1'b1;
              res         = summarize(hdr_r, 1'b1, 28'd0, topic_r, msg_r, connack_r,
                                      suback_r, proto_v5);
            end
          end else if (len_acc_nxt == 28'd0) begin
            // Empty body: summary on the length byte
            phase_nxt = mrp_pkg::PH_IDLE;
            res_vld   = 1'b1;
          end else begin
            left_nxt  = len_acc_nxt;
            phase_nxt = mrp_pkg::PH_BODY;
          end
        end
        default: begin
          // Body field capture by position
          if (cur_type == mrp_pkg::PT_PUBLISH) begin
            if (pos_r == 28'd0) begin
              topic_nxt = {rx_byte, 8'd0};
            end else if (pos_r == 28'd1) begin
              topic_nxt = {topic_r[15:8], rx_byte};
            end else if (qos_nz) begin
              if (pos_r == {12'd0, topic_r} + 28'd2) begin
                msg_nxt = {rx_byte, 8'd0};
              end else if (pos_r == {12'd0, topic_r} + 28'd3) begin
                msg_nxt = {msg_r[15:8], rx_byte};
              end
            end
          end else if (cur_type == mrp_pkg::PT_CONNACK) begin
            if (pos_r == 28'd0) begin
              connack_nxt = {rx_byte, 8'd0};
            end else if (pos_r == 28'd1) begin
              connack_nxt = {connack_r[15:8], rx_byte};
            end
          end else begin
            if (pos_r == 28'd0) begin
              msg_nxt = {rx_byte, 8'd0};
            end else if (pos_r == 28'd1) begin
              msg_nxt = {msg_r[15:8], rx_byte};
            end else if (cur_type == mrp_pkg::PT_SUBACK) begin
              // Return code count saturates at all ones
              suback_nxt[23:8] = (sub_cnt != 16'hFFFF) ? sub_cnt + 16'd1 : sub_cnt;
              suback_nxt[7:0]  = (pos_r == 28'd2) ? rx_byte : sub_fc;
            end
          end
          pos_nxt  = pos_r + 28'd1;
          left_nxt = left_r - 28'd1;
          if (left_nxt == 28'd0) begin
            phase_nxt = mrp_pkg::PH_IDLE;
            res_vld   = 1'b1;
            res       = summarize(hdr_r, 1'b0, len_acc_r, topic_nxt, msg_nxt,
                                  connack_nxt, suback_nxt, proto_v5);
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= mrp_pkg::PH_IDLE;
      hdr_r     <= '0;
      len_acc_r <= '0;
      len_cnt_r <= '0;
      left_r    <= '0;
      pos_r     <= '0;
      topic_r   <= '0;
      msg_r     <= '0;
      connack_r <= '0;
      suback_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_r     <= hdr_nxt;
      len_acc_r <= len_acc_nxt;
      len_cnt_r <= len_cnt_nxt;
      left_r    <= left_nxt;
      pos_r     <= pos_nxt;
      topic_r   <= topic_nxt;
      msg_r     <= msg_nxt;
      connack_r <= connack_nxt;
      suback_r  <= suback_nxt;
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// MQTT receive packet parser testbench
// Feeds whole MQTT packets byte by byte (well-formed, truncated, over-long
// length fields, unhandled types and random junk) under random input gaps
// and output stalls, across several protocol levels. A local model of the
// parser predicts each packet summary and the monitor checks every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  // Packet types the parser never handles
  localparam logic [3:0] PT_RESERVED    = 4'd0;
  localparam logic [3:0] PT_CONNECT     = 4'd1;
  localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] PT_UNSUBACK    = 4'd11;
  localparam logic [3:0] PT_PINGREQ     = 4'd12;
  localparam logic [3:0] PT_PINGRESP    = 4'd13;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_PRINTS  = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_packet_type;
  logic [3:0]  out_header_flags;
  logic [27:0] out_pkt_len;
  logic [15:0] out_message_id;
  logic [15:0] out_topic_length;
  logic [27:0] out_payload_length;
  logic [7:0]  out_ack_flags;
  logic [7:0]  out_reason_code;
  logic [15:0] out_code_count;
  logic [7:0]  out_first_code;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_protocol_version = 3'd0;

  mqtt_receive_packet_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_packet_type      (out_packet_type),
    .out_header_flags     (out_header_flags),
    .out_pkt_len          (out_pkt_len),
    .out_message_id       (out_message_id),
    .out_topic_length     (out_topic_length),
    .out_payload_length   (out_payload_length),
    .out_ack_flags        (out_ack_flags),
    .out_reason_code      (out_reason_code),
    .out_code_count       (out_code_count),
    .out_first_code       (out_first_code),
    .out_status           (out_status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_protocol_version (cfg_protocol_version)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stream bytes waiting to be sent, and summaries waiting to come out
  logic [7:0]  pending_bytes[$];
  logic [7:0]  body_buf[$];
  mrp_pkg::mrp_result_t summary_q[$];
  int unsigned queued_bytes = 0;
  int unsigned err_count = 0;

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  logic [2:0]  proto_level = mrp_pkg::PROTO_DEFAULT;
  mrp_pkg::mrp_phase_t prs_phase = mrp_pkg::PH_IDLE;
  logic [7:0]  hdr_byte;
  logic [27:0] len_acc;
  logic [2:0]  len_cnt;
  logic [27:0] remain;
  logic [27:0] body_pos;
  logic [15:0] topic_len;
  logic [15:0] msg_id;
  logic [15:0] connack_word;
  logic [15:0] sub_count;
  logic [7:0]  sub_first;

  function automatic bit type_ok(input logic [3:0] t);
    case (t)
      mrp_pkg::PT_CONNACK, mrp_pkg::PT_PUBLISH, mrp_pkg::PT_PUBACK, mrp_pkg::PT_PUBREC,
      mrp_pkg::PT_PUBREL, mrp_pkg::PT_PUBCOMP, mrp_pkg::PT_SUBACK: return 1'b1;
      mrp_pkg::PT_DISCONNECT, mrp_pkg::PT_AUTH: return proto_level >= mrp_pkg::PROTO_V5;
      default: return 1'b0;
    endcase
  endfunction

  // Build the summary of the current packet and return to idle
  function automatic void finish_packet(input mrp_pkg::mrp_status_t st_in,
                                        input logic [27:0] rl);
    mrp_pkg::mrp_result_t r;
    mrp_pkg::mrp_status_t st;
    logic [3:0]  t;
    logic [1:0]  qos;
    logic [27:0] rest;
    t = hdr_byte[7:4];
    qos = hdr_byte[2:1];
    st = st_in;
    r = '0;
    if (st == mrp_pkg::ST_ACCEPTED && !type_ok(t)) st = mrp_pkg::ST_IGNORED;
    if (st == mrp_pkg::ST_ACCEPTED) begin
      case (t)
        mrp_pkg::PT_PUBLISH: begin
          if (rl < 28'd2 || 32'd2 + {16'd0, topic_len} > {4'd0, rl}) begin
            st = mrp_pkg::ST_SHORT;
          end else begin
            rest = rl - 28'd2 - {12'd0, topic_len};
            if (qos != 2'd0) begin
              if (rest < 28'd2) begin
                st = mrp_pkg::ST_SHORT;
              end else begin
                rest = rest - 28'd2;
                r.message_id = msg_id;
              end
            end
            r.topic_length = topic_len;
            r.payload_length = rest;
          end
        end
        mrp_pkg::PT_CONNACK: begin
          if (rl < 28'd2) st = mrp_pkg::ST_SHORT;
          else begin
            r.ack_flags = connack_word[15:8];
            r.reason_code = connack_word[7:0];
          end
        end
        mrp_pkg::PT_SUBACK: begin
          if (rl < 28'd3) st = mrp_pkg::ST_SHORT;
          else begin
            r.message_id = msg_id;
            r.code_count = sub_count;
            r.first_code = sub_first;
          end
        end
        mrp_pkg::PT_DISCONNECT: ;
        default: begin
          if (rl < 28'd2) st = mrp_pkg::ST_SHORT;
          else r.message_id = msg_id;
        end
      endcase
    end
    // only type, flags and length survive a rejected packet
    if (st != mrp_pkg::ST_ACCEPTED) r = '0;
    r.packet_type = t;
    r.header_flags = hdr_byte[3:0];
    r.pkt_len = rl;
    r.status = st;
    summary_q.push_back(r);
    prs_phase = mrp_pkg::PH_IDLE;
  endfunction

  // Pick up the fields carried by one body byte
  function automatic void grab_body_byte(input logic [7:0] b);
    logic [3:0]  t;
    logic [1:0]  qos;
    logic [31:0] p;
    t = hdr_byte[7:4];
    qos = hdr_byte[2:1];
    if (t == mrp_pkg::PT_PUBLISH) begin
      if (body_pos == 28'd0) topic_len = {b, 8'h00};
      else if (body_pos == 28'd1) topic_len[7:0] = b;
      else if (qos != 2'd0) begin
        p = {4'd0, body_pos} - 32'd2;
        if (p == {16'd0, topic_len}) msg_id = {b, 8'h00};
        else if (p == {16'd0, topic_len} + 32'd1) msg_id[7:0] = b;
      end
    end else if (t == mrp_pkg::PT_CONNACK) begin
      if (body_pos == 28'd0) connack_word = {b, 8'h00};
      else if (body_pos == 28'd1) connack_word[7:0] = b;
    end else begin
      if (body_pos == 28'd0) msg_id = {b, 8'h00};
      else if (body_pos == 28'd1) msg_id[7:0] = b;
      else if (t == mrp_pkg::PT_SUBACK) begin
        if (body_pos == 28'd2) sub_first = b;
        if (sub_count != 16'hFFFF) sub_count = sub_count + 16'd1;
      end
    end
    body_pos = body_pos + 28'd1;
  endfunction

  // Advance the model by one accepted stream byte
  function automatic void parse_byte(input logic [7:0] b);
    int unsigned sh;
    case (prs_phase)
      mrp_pkg::PH_IDLE: begin
        hdr_byte = b;
        len_acc = '0;
        len_cnt = '0;
        remain = '0;
        body_pos = '0;
        topic_len = '0;
        msg_id = '0;
        connack_word = '0;
        sub_count = '0;
        sub_first = '0;
        prs_phase = mrp_pkg::PH_LEN;
      end
      mrp_pkg::PH_LEN: begin
        sh = 7 * (len_cnt & 3'd3);
        len_acc = len_acc + ({21'd0, b[6:0]} << sh);
        len_cnt = len_cnt + 3'd1;
        if (b[7]) begin
          if (len_cnt >= mrp_pkg::MAX_LEN_BYTES) begin
            len_cnt = '0;
            finish_packet(mrp_pkg::ST_TOO_LONG, 28'd0);
          end
        end else if (len_acc == 28'd0) begin
          finish_packet(mrp_pkg::ST_ACCEPTED, 28'd0);
        end else begin
          remain = len_acc;
          prs_phase = mrp_pkg::PH_BODY;
        end
      end
      default: begin
        grab_body_byte(b);
        remain = remain - 28'd1;
        if (remain == 28'd0) finish_packet(mrp_pkg::ST_ACCEPTED, len_acc);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string text);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, text);
  endtask

  task automatic check_field(input string name, input logic [27:0] got,
                             input logic [27:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: one transfer per queued byte, random gap before each
  // --------------------------------------------------------------------------
  int unsigned in_gap = 0;
  bit          in_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) parse_byte(in_rx_byte);
      // a stalled byte stays on the bus unchanged
      if (!(in_valid && in_stall)) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
          in_gap <= in_burst ? 0 : $urandom_range(0, 8);
          if ($urandom_range(0, 63) == 0) in_burst <= !in_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Summary monitor: random stall after each transfer
  // --------------------------------------------------------------------------
  int unsigned hold_cnt = 0;
  bit          out_burst = 1'b0;

  always @(posedge clk) begin : watch_summaries
    mrp_pkg::mrp_result_t want;
    int unsigned w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (out_valid && !out_stall) begin
      if (summary_q.size() == 0) begin
        report_mismatch($sformatf("unexpected summary, type %0d status %0d",
                                  out_packet_type, out_status));
      end else begin
        want = summary_q.pop_front();
        check_field("packet_type", 28'(out_packet_type), 28'(want.packet_type));
        check_field("header_flags", 28'(out_header_flags), 28'(want.header_flags));
        check_field("pkt_len", out_pkt_len, want.pkt_len);
        check_field("message_id", 28'(out_message_id), 28'(want.message_id));
        check_field("topic_length", 28'(out_topic_length), 28'(want.topic_length));
        check_field("payload_length", out_payload_length, want.payload_length);
        check_field("ack_flags", 28'(out_ack_flags), 28'(want.ack_flags));
        check_field("reason_code", 28'(out_reason_code), 28'(want.reason_code));
        check_field("code_count", 28'(out_code_count), 28'(want.code_count));
        check_field("first_code", 28'(out_first_code), 28'(want.first_code));
        check_field("status", 28'(out_status), 28'(want.status));
      end
      w = out_burst ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 63) == 0) out_burst <= !out_burst;
      out_stall <= (w != 0);
      hold_cnt <= w;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      hold_cnt <= 0;
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transfer
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Packet building
  // --------------------------------------------------------------------------

  // Header, length field (optionally padded with zero groups), then body_buf
  task automatic push_packet(input logic [7:0] hdr, input int unsigned pad);
    logic [7:0]  enc[$];
    int unsigned n;
    int unsigned k;
    n = body_buf.size();
    do begin
      enc.push_back({1'b0, n[6:0]});
      n = n >> 7;
      if (n != 0) enc[enc.size() - 1][7] = 1'b1;
    end while (n != 0);
    for (k = 0; k < pad && enc.size() < mrp_pkg::MAX_LEN_BYTES; k++) begin
      enc[enc.size() - 1][7] = 1'b1;
      enc.push_back(8'h00);
    end
    pending_bytes.push_back(hdr);
    foreach (enc[i]) pending_bytes.push_back(enc[i]);
    foreach (body_buf[i]) pending_bytes.push_back(body_buf[i]);
    queued_bytes += 1 + enc.size() + body_buf.size();
  endtask

  // Length field whose last allowed byte still has the continuation bit
  task automatic push_overlong(input logic [7:0] hdr, input bit all_ones);
    int unsigned k;
    pending_bytes.push_back(hdr);
    for (k = 0; k < mrp_pkg::MAX_LEN_BYTES; k++)
      pending_bytes.push_back(all_ones ? 8'hFF : (8'h80 | 8'($urandom_range(0, 127))));
    queued_bytes += 1 + mrp_pkg::MAX_LEN_BYTES;
  endtask

  task automatic fill_random(input int unsigned n);
    repeat (n) body_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_publish(input logic [1:0] qos, input int unsigned tn,
                               input logic [15:0] id, input int unsigned pn);
    body_buf.delete();
    body_buf.push_back(tn[15:8]);
    body_buf.push_back(tn[7:0]);
    fill_random(tn);
    if (qos != 2'd0) begin
      body_buf.push_back(id[15:8]);
      body_buf.push_back(id[7:0]);
    end
    fill_random(pn);
  endtask

  function automatic bit ever_handled(input logic [3:0] t);
    case (t)
      mrp_pkg::PT_CONNACK, mrp_pkg::PT_PUBLISH, mrp_pkg::PT_PUBACK, mrp_pkg::PT_PUBREC,
      mrp_pkg::PT_PUBREL, mrp_pkg::PT_PUBCOMP, mrp_pkg::PT_SUBACK, mrp_pkg::PT_DISCONNECT,
      mrp_pkg::PT_AUTH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // One random packet: mostly well-formed, some truncated or junk
  task automatic random_packet();
    int unsigned r;
    int unsigned pad;
    int unsigned tn;
    int unsigned pn;
    logic [3:0]  fl;
    logic [3:0]  t;
    r = $urandom_range(0, 99);
    fl = 4'($urandom_range(0, 15));
    pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    body_buf.delete();
    if (r < 22) begin
      tn = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 8);
      pn = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
      build_publish(fl[2:1], tn, 16'($urandom), pn);
      push_packet({mrp_pkg::PT_PUBLISH, fl}, pad);
    end else if (r < 30) begin
      fill_random(2);
      push_packet({mrp_pkg::PT_CONNACK, fl}, pad);
    end else if (r < 44) begin
      fill_random(($urandom_range(0, 3) == 0) ? $urandom_range(3, 4) : 2);
      push_packet({4'($urandom_range(mrp_pkg::PT_PUBACK, mrp_pkg::PT_PUBCOMP)), fl}, pad);
    end else if (r < 54) begin
      fill_random(2 + $urandom_range(1, 6));
      push_packet({mrp_pkg::PT_SUBACK, fl}, pad);
    end else if (r < 62) begin
      fill_random($urandom_range(0, 3));
      push_packet({($urandom_range(0, 1) != 0) ? mrp_pkg::PT_AUTH : mrp_pkg::PT_DISCONNECT,
                   fl}, pad);
    end else if (r < 69) begin
      do t = 4'($urandom_range(0, 15)); while (ever_handled(t));
      fill_random($urandom_range(0, 5));
      push_packet({t, fl}, pad);
    end else if (r < 77) begin
      push_overlong({4'($urandom_range(0, 15)), fl}, 1'b0);
    end else if (r < 90) begin
      fill_random($urandom_range(0, 3));
      push_packet({4'($urandom_range(0, 15)), fl}, pad);
    end else begin
      fill_random($urandom_range(0, 24));
      push_packet({4'($urandom_range(0, 15)), fl}, pad);
    end
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned start;
    start = queued_bytes;
    while (queued_bytes - start < target) random_packet();
  endtask

  // Wait for every queued byte and summary, then let the pipeline drain
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || summary_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_level(input logic [2:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_protocol_version <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    proto_level = v;
  endtask

  // --------------------------------------------------------------------------
  // Directed packets at the default level
  // --------------------------------------------------------------------------
  task automatic directed_default();
    body_buf = '{8'h01, 8'h00};          push_packet({mrp_pkg::PT_CONNACK, 4'h0}, 0);
    body_buf = '{8'h00};                 push_packet({mrp_pkg::PT_CONNACK, 4'h0}, 0);
    body_buf = '{8'hFF, 8'hFF, 8'h00};   push_packet({mrp_pkg::PT_CONNACK, 4'hF}, 0);
    // QoS 0, 1, 3; the QoS 1 packet has an empty topic and payload
    build_publish(2'd0, 3, 16'h0000, 2);  push_packet({mrp_pkg::PT_PUBLISH, 4'b0000}, 0);
    build_publish(2'd1, 0, 16'hFFFF, 0);  push_packet({mrp_pkg::PT_PUBLISH, 4'b0010}, 0);
    build_publish(2'd3, 1, 16'h1234, 3);  push_packet({mrp_pkg::PT_PUBLISH, 4'b1111}, 0);
    // no room for the message id, topic longer than the packet, too short
    body_buf = '{8'h00, 8'h02, 8'h61, 8'h62};
    push_packet({mrp_pkg::PT_PUBLISH, 4'b0100}, 0);
    body_buf = '{8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03};
    push_packet({mrp_pkg::PT_PUBLISH, 4'b0001}, 0);
    body_buf = '{8'h00};                 push_packet({mrp_pkg::PT_PUBLISH, 4'b0000}, 0);
    body_buf.delete();                   push_packet({mrp_pkg::PT_PUBLISH, 4'b0000}, 0);
    // acks
    body_buf = '{8'h00, 8'h00};          push_packet({mrp_pkg::PT_PUBACK, 4'h0}, 0);
    body_buf = '{8'hFF, 8'hFF};          push_packet({mrp_pkg::PT_PUBREC, 4'h0}, 0);
    body_buf = '{8'h00, 8'hAB, 8'h10};   push_packet({mrp_pkg::PT_PUBREL, 4'h2}, 0);
    body_buf = '{8'h12};                 push_packet({mrp_pkg::PT_PUBCOMP, 4'h0}, 0);
    // SUBACK with codes, and with none
    body_buf = '{8'h00, 8'h05, 8'h00, 8'h01, 8'h80};
    push_packet({mrp_pkg::PT_SUBACK, 4'h0}, 0);
    body_buf = '{8'h00, 8'h06};          push_packet({mrp_pkg::PT_SUBACK, 4'h0}, 0);
    // v5-only types rejected here
    body_buf.delete();                   push_packet({mrp_pkg::PT_DISCONNECT, 4'h0}, 0);
    body_buf = '{8'h00, 8'h01};          push_packet({mrp_pkg::PT_AUTH, 4'h0}, 0);
    // unhandled types
    body_buf.delete();                   push_packet({PT_RESERVED, 4'h0}, 0);
    body_buf = '{8'h00, 8'h04};          push_packet({PT_CONNECT, 4'h0}, 0);
    body_buf = '{8'h00, 8'h01, 8'h00};   push_packet({PT_SUBSCRIBE, 4'h2}, 0);
    body_buf = '{8'h00, 8'h01};          push_packet({PT_UNSUBSCRIBE, 4'h2}, 0);
    body_buf = '{8'h00, 8'h01};          push_packet({PT_UNSUBACK, 4'h0}, 0);
    body_buf.delete();                   push_packet({PT_PINGREQ, 4'h0}, 0);
    body_buf.delete();                   push_packet({PT_PINGRESP, 4'h0}, 0);
    // over-long length field, all ones
    push_overlong(8'hFF, 1'b1);
    // longest legal length field, non-minimal encoding
    body_buf = '{8'h43, 8'h21};          push_packet({mrp_pkg::PT_PUBACK, 4'h0}, 3);
    body_buf.delete();                   push_packet({mrp_pkg::PT_PUBREL, 4'h0}, 3);
  endtask

  task automatic directed_v5();
    body_buf.delete();                   push_packet({mrp_pkg::PT_DISCONNECT, 4'h0}, 0);
    body_buf = '{8'h00};                 push_packet({mrp_pkg::PT_DISCONNECT, 4'h0}, 0);
    body_buf = '{8'h00, 8'h18};          push_packet({mrp_pkg::PT_AUTH, 4'h0}, 0);
    body_buf = '{8'h18};                 push_packet({mrp_pkg::PT_AUTH, 4'h0}, 0);
    push_overlong({mrp_pkg::PT_DISCONNECT, 4'h0}, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [2:0] phase_levels[6] = '{3'd7, 3'd0, 3'd3, 3'd5, 3'd6, 3'd2};

  initial begin : run_phases
    int unsigned ph;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset level first, unwritten
    @(negedge clk);
    directed_default();
    settle();

    write_level(mrp_pkg::PROTO_V5);
    @(negedge clk);
    directed_v5();
    settle();

    for (ph = 0; ph < 6; ph++) begin
      write_level(phase_levels[ph]);
      @(negedge clk);
      random_phase(175);
      settle();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
